// ----- rtl/core/lcs_pkg.sv -----
// Shared constants, types and the controller state encoding for the lever calibrate/scale block.
package lcs_pkg;

  // Default sample width; legal range is 8..16
  localparam int unsigned SAMPLE_BITS_DEF = 10;

  // Key field layout
  localparam int unsigned KEY_BITS    = 12;
  localparam int unsigned KEY_TEST    = 0;
  localparam int unsigned KEY_SERVICE = 1;
  localparam int unsigned KEY_FIRST   = 5;
  localparam int unsigned KEY_SECOND  = 6;
  localparam int unsigned KEY_SHIFT   = 10;
  localparam int unsigned KEY_COIN    = 11;

  // Result field widths
  localparam int unsigned POS_BITS    = 16;
  localparam int unsigned OPT_BITS    = 3;
  localparam int unsigned BUTTON_BITS = 10;
  localparam int unsigned OUT_FIELD_W = POS_BITS + OPT_BITS + BUTTON_BITS;
  localparam int unsigned OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

  // Divider: one quotient bit per cycle
  localparam int unsigned QUO_BITS = 16;
  localparam int unsigned STEP_W   = $clog2(QUO_BITS);

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_SETUP,
    ST_DIV,
    ST_FINISH
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;   // capture request, update limits
    logic prep;   // mirror, clamp, differences
    logic setup;  // form numerator, seed divider
    logic step;   // one restoring divide step
    logic emit;   // write the output register
  } dp_cmd_t;

endpackage

// ----- rtl/core/lcs_ctrl.sv -----
// Sequencer for one request: prepare, seed the divider, 16 divide steps, hand off the result.
module lcs_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output lcs_pkg::dp_cmd_t cmd_o
);

  lcs_pkg::state_e state_q, state_d;
  logic [lcs_pkg::STEP_W-1:0] cnt_q, cnt_d;
  logic out_valid_q, out_valid_d;
  logic in_fire;
  logic out_free;
  logic last_step;

  assign in_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free  = !out_valid_q || m_axis_tready_i;
  assign last_step = (cnt_q == lcs_pkg::STEP_W'(lcs_pkg::QUO_BITS - 1));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lcs_pkg::ST_IDLE:   if (in_fire) state_d = lcs_pkg::ST_PREP;
      lcs_pkg::ST_PREP:   state_d = lcs_pkg::ST_SETUP;
      lcs_pkg::ST_SETUP:  state_d = lcs_pkg::ST_DIV;
      lcs_pkg::ST_DIV:    if (last_step) state_d = lcs_pkg::ST_FINISH;
      lcs_pkg::ST_FINISH: if (out_free) state_d = lcs_pkg::ST_IDLE;
      default:            state_d = lcs_pkg::ST_IDLE;
    endcase
  end

  // Outputs and commands
  always_comb begin
    cmd_o           = '0;
    s_axis_tready_o = 1'b0;
    case (state_q)
      lcs_pkg::ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        cmd_o.load      = s_axis_tvalid_i;
      end
      lcs_pkg::ST_PREP:   cmd_o.prep  = 1'b1;
      lcs_pkg::ST_SETUP:  cmd_o.setup = 1'b1;
      lcs_pkg::ST_DIV:    cmd_o.step  = 1'b1;
      lcs_pkg::ST_FINISH: cmd_o.emit  = out_free;
      default: ;
    endcase
  end

  // Step counter and output-valid flag
  always_comb begin
    cnt_d = cnt_q;
    if (state_q == lcs_pkg::ST_SETUP) begin
      cnt_d = '0;
    end else if (state_q == lcs_pkg::ST_DIV) begin
      cnt_d = cnt_q + 1'b1;
    end
    out_valid_d = out_valid_q;
    if (m_axis_tready_i) out_valid_d = 1'b0;
    if (cmd_o.emit) out_valid_d = 1'b1;
  end

  assign m_axis_tvalid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lcs_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- rtl/core/lcs_dp.sv -----
// Datapath: calibration limits, mirror and clamp, serial restoring divider, output register.
module lcs_dp #(
  parameter int unsigned SAMPLE_BITS = lcs_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  lcs_pkg::dp_cmd_t                cmd_i,
  input  logic [SAMPLE_BITS-1:0]          sample_i,
  input  logic [lcs_pkg::KEY_BITS-1:0]    keys_i,
  output logic [lcs_pkg::POS_BITS-1:0]    pos_o,
  output logic [lcs_pkg::OPT_BITS-1:0]    opt_o,
  output logic [lcs_pkg::BUTTON_BITS-1:0] buttons_o
);

  localparam int unsigned QB    = lcs_pkg::QUO_BITS;
  localparam int unsigned NUM_W = SAMPLE_BITS + QB;

  logic [SAMPLE_BITS-1:0] first_q, second_q;
  logic [SAMPLE_BITS-1:0] sample_q;
  logic [lcs_pkg::OPT_BITS-1:0]    opt_q;
  logic [lcs_pkg::BUTTON_BITS-1:0] btn_q;
  logic [SAMPLE_BITS-1:0] diff_q, den_q;
  logic                   den_zero_q;
  logic [SAMPLE_BITS-1:0] rem_q;
  logic [QB-1:0]          quo_q;
  logic [lcs_pkg::POS_BITS-1:0]    pos_q;
  logic [lcs_pkg::OPT_BITS-1:0]    opt_out_q;
  logic [lcs_pkg::BUTTON_BITS-1:0] btn_out_q;

  logic shift_key;
  logic [lcs_pkg::OPT_BITS-1:0]    opt_d;
  logic [lcs_pkg::BUTTON_BITS-1:0] btn_d;

  // Key decode at request capture
  always_comb begin
    shift_key = keys_i[lcs_pkg::KEY_SHIFT];
    opt_d     = {keys_i[lcs_pkg::KEY_COIN],
                 shift_key & keys_i[lcs_pkg::KEY_SERVICE],
                 shift_key & keys_i[lcs_pkg::KEY_TEST]};
    btn_d     = shift_key ? '0 : keys_i[lcs_pkg::BUTTON_BITS-1:0];
  end

  // Calibration limits; key5 capture wins over key6
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q  <= '0;
      second_q <= '1;
    end else if (cmd_i.load && shift_key) begin
      if (keys_i[lcs_pkg::KEY_FIRST]) begin
        first_q <= sample_i;
      end else if (keys_i[lcs_pkg::KEY_SECOND]) begin
        second_q <= sample_i;
      end
    end
  end

  // Mirror when limits are reversed (M - v is ~v), then clamp
  logic                   ordered;
  logic [SAMPLE_BITS-1:0] x_m, left_m, right_m, x_c;
  always_comb begin
    ordered = (first_q < second_q);
    x_m     = ordered ? sample_q : ~sample_q;
    left_m  = ordered ? first_q  : ~first_q;
    right_m = ordered ? second_q : ~second_q;
    if (x_m < left_m) begin
      x_c = left_m;
    end else if (x_m > right_m) begin
      x_c = right_m;
    end else begin
      x_c = x_m;
    end
  end

  // Numerator (x-left)*65535 as a shift and subtract
  logic [NUM_W-1:0] num;
  assign num = {diff_q, {QB{1'b0}}} - NUM_W'(diff_q);

  // One restoring divide step
  logic [SAMPLE_BITS:0] trial, trial_sub;
  always_comb begin
    trial     = {rem_q, quo_q[QB-1]};
    trial_sub = trial - {1'b0, den_q};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sample_q <= sample_i;
      opt_q    <= opt_d;
      btn_q    <= btn_d;
    end
    if (cmd_i.prep) begin
      diff_q     <= x_c - left_m;
      den_q      <= right_m - left_m;
      den_zero_q <= (right_m == left_m);
    end
    if (cmd_i.setup) begin
      rem_q <= num[NUM_W-1:QB];
      quo_q <= num[QB-1:0];
    end else if (cmd_i.step) begin
      if (!trial_sub[SAMPLE_BITS]) begin
        rem_q <= trial_sub[SAMPLE_BITS-1:0];
        quo_q <= {quo_q[QB-2:0], 1'b1};
      end else begin
        rem_q <= trial[SAMPLE_BITS-1:0];
        quo_q <= {quo_q[QB-2:0], 1'b0};
      end
    end
    // Output register; adding -32768 flips the top bit
    if (cmd_i.emit) begin
      pos_q     <= den_zero_q ? {1'b1, {(lcs_pkg::POS_BITS-1){1'b0}}}
                              : {~quo_q[QB-1], quo_q[QB-2:0]};
      opt_out_q <= opt_q;
      btn_out_q <= btn_q;
    end
  end

  assign pos_o     = pos_q;
  assign opt_o     = opt_out_q;
  assign buttons_o = btn_out_q;

endmodule

// ----- rtl/core/lever_calibrate_clamp_scale_top.sv -----
// Top level of the lever calibrate, clamp and scale block.
//
//  Channel   Dir  tdata fields (low bit first)
//  s_axis    in   lever_sample[SAMPLE_BITS], key_bits[12], zero fill to bytes
//  m_axis    out  lever_position[16], option_bits[3], game_buttons[10], 3 zero bits
//
// One request at a time: a new request is taken only after the previous one
// has gone through capture, prepare, seed, the serial restoring divider (16
// steps, one quotient bit per cycle) and hand-off. The output register lets
// a new request be taken while the previous result waits; a stalled result
// holds the block in its hand-off cycle. Reset restores limits 0 and all-ones.
module lever_calibrate_clamp_scale_top #(
  parameter int unsigned SAMPLE_BITS = lcs_pkg::SAMPLE_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // lever_sample, key_bits
  input  logic [((SAMPLE_BITS + lcs_pkg::KEY_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata_i,
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  // lever_position, option_bits, game_buttons
  output logic [lcs_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);

  localparam int unsigned KEY_LO = SAMPLE_BITS;

  lcs_pkg::dp_cmd_t cmd;
  logic [lcs_pkg::POS_BITS-1:0]    pos;
  logic [lcs_pkg::OPT_BITS-1:0]    opt;
  logic [lcs_pkg::BUTTON_BITS-1:0] buttons;

  lcs_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .cmd_o           (cmd)
  );

  lcs_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .sample_i  (s_axis_tdata_i[SAMPLE_BITS-1:0]),
    .keys_i    (s_axis_tdata_i[KEY_LO + lcs_pkg::KEY_BITS - 1:KEY_LO]),
    .pos_o     (pos),
    .opt_o     (opt),
    .buttons_o (buttons)
  );

  // Pack result fields, zero fill to whole bytes
  assign m_axis_tdata_o = lcs_pkg::OUT_DATA_W'({buttons, opt, pos});

endmodule

// ----- sim/tb_lever_calibrate_clamp_scale_top.sv -----
// Testbench for the lever calibrate, clamp and scale block: stream driver, monitor and scoreboard.
module tb_lever_calibrate_clamp_scale_top;

  localparam int unsigned SAMPLE_W    = lcs_pkg::SAMPLE_BITS_DEF;
  localparam int unsigned KEY_W       = lcs_pkg::KEY_BITS;
  localparam int unsigned IN_DATA_W   = ((SAMPLE_W + KEY_W + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W  = lcs_pkg::OUT_DATA_W;
  localparam int unsigned POS_W       = lcs_pkg::POS_BITS;
  localparam int unsigned OPT_W       = lcs_pkg::OPT_BITS;
  localparam int unsigned BTN_W       = lcs_pkg::BUTTON_BITS;
  localparam int unsigned SAMPLE_TOP  = (1 << SAMPLE_W) - 1;
  localparam int unsigned RESET_CYC   = 7;
  localparam int unsigned DRAIN_CYC   = 40;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned RANDOM_ITEMS = 410;
  localparam int unsigned STALL_AT    = 60;
  localparam int unsigned STALL_CYC   = 250;

  // Key masks
  localparam logic [KEY_W-1:0] M_SHIFT   = KEY_W'(1) << lcs_pkg::KEY_SHIFT;
  localparam logic [KEY_W-1:0] M_FIRST   = KEY_W'(1) << lcs_pkg::KEY_FIRST;
  localparam logic [KEY_W-1:0] M_SECOND  = KEY_W'(1) << lcs_pkg::KEY_SECOND;
  localparam logic [KEY_W-1:0] M_TEST    = KEY_W'(1) << lcs_pkg::KEY_TEST;
  localparam logic [KEY_W-1:0] M_SERVICE = KEY_W'(1) << lcs_pkg::KEY_SERVICE;
  localparam logic [KEY_W-1:0] M_COIN    = KEY_W'(1) << lcs_pkg::KEY_COIN;
  localparam logic [KEY_W-1:0] M_BUTTONS = KEY_W'((1 << BTN_W) - 1);

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [KEY_W-1:0]    keys;
  } lever_req_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [OPT_W-1:0] opt;
    logic [BTN_W-1:0] buttons;
  } lever_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [IN_DATA_W-1:0] s_axis_tdata_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;

  lever_req_t    pending_reqs[$];
  lever_result_t lever_expect_q[$];

  // Calibration limits as the block should hold them
  logic [SAMPLE_W-1:0] lim_first  = '0;
  logic [SAMPLE_W-1:0] lim_second = SAMPLE_W'(SAMPLE_TOP);

  int unsigned accept_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 16;
  int unsigned recv_idle_pct = 49;
  int unsigned stall_left = 0;
  bit          stall_done = 1'b0;

  lever_calibrate_clamp_scale_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #5 clk_i = ~clk_i;

  // Capture, mirror, clamp and map one request; updates the limits
  function automatic lever_result_t calibrate_lever(input lever_req_t req);
    lever_result_t res;
    logic          shift;
    int unsigned   x;
    int unsigned   left;
    int unsigned   right;
    int unsigned   quot;
    shift = req.keys[lcs_pkg::KEY_SHIFT];
    if (shift && req.keys[lcs_pkg::KEY_FIRST]) begin
      lim_first = req.sample;
    end else if (shift && req.keys[lcs_pkg::KEY_SECOND]) begin
      lim_second = req.sample;
    end
    if (lim_first < lim_second) begin
      x     = req.sample;
      left  = lim_first;
      right = lim_second;
    end else begin
      x     = SAMPLE_TOP - req.sample;
      left  = SAMPLE_TOP - lim_first;
      right = SAMPLE_TOP - lim_second;
    end
    if (x < left) begin
      x = left;
    end else if (x > right) begin
      x = right;
    end
    // equal limits pin the position to the bottom of the range
    if (right == left) begin
      quot = 0;
    end else begin
      quot = ((x - left) * 65535) / (right - left);
    end
    res.pos = POS_W'(int'(quot) - 32768);
    res.opt = {req.keys[lcs_pkg::KEY_COIN],
               shift & req.keys[lcs_pkg::KEY_SERVICE],
               shift & req.keys[lcs_pkg::KEY_TEST]};
    res.buttons = shift ? '0 : req.keys[BTN_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: ERROR %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 6) begin
      return '0;
    end else if (r < 12) begin
      return SAMPLE_W'(SAMPLE_TOP);
    end
    return SAMPLE_W'($urandom);
  endfunction

  function automatic void add_req(input int unsigned sample, input int unsigned keys);
    lever_req_t req;
    req.sample = SAMPLE_W'(sample);
    req.keys   = KEY_W'(keys);
    pending_reqs.push_back(req);
  endfunction

  // Cycle counter for the timeout
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // Request driver; predicts each accepted request
  always @(posedge clk_i or negedge rst_ni) begin
    lever_req_t req;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        req.sample = s_axis_tdata_i[SAMPLE_W-1:0];
        req.keys   = s_axis_tdata_i[SAMPLE_W +: KEY_W];
        lever_expect_q.push_back(calibrate_lever(req));
        accept_count <= accept_count + 1;
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req = pending_reqs.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= IN_DATA_W'({req.keys, req.sample});
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off so the block backs up into its input
  always @(posedge clk_i) begin
    if (!stall_done && accept_count >= STALL_AT) begin
      stall_left <= STALL_CYC;
      stall_done <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // Receiver ready
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= (stall_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Result monitor and compare
  always @(posedge clk_i) begin
    lever_result_t want;
    lever_result_t got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.pos     = m_axis_tdata_o[POS_W-1:0];
      got.opt     = m_axis_tdata_o[POS_W +: OPT_W];
      got.buttons = m_axis_tdata_o[POS_W + OPT_W +: BTN_W];
      if (lever_expect_q.size() == 0) begin
        report_mismatch("unexpected result", int'(m_axis_tdata_o), 0);
      end else begin
        want = lever_expect_q.pop_front();
        if (got.pos !== want.pos) begin
          report_mismatch("lever_position", int'(got.pos), int'(want.pos));
        end
        if (got.opt !== want.opt) begin
          report_mismatch("option_bits", int'(got.opt), int'(want.opt));
        end
        if (got.buttons !== want.buttons) begin
          report_mismatch("game_buttons", int'(got.buttons), int'(want.buttons));
        end
      end
    end
  end

  // Timeout
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Stimulus, idle phases and end of run
  initial begin
    int unsigned r;
    int unsigned keys;
    logic [SAMPLE_W-1:0] s;

    // directed: extremes, captures, clamps, equal and reversed limits
    add_req(0, 0);
    add_req(SAMPLE_TOP, 0);
    add_req(512, M_BUTTONS);
    add_req(511, '1);                           // every key, first capture wins
    add_req(300, 0);                            // below first limit
    add_req(SAMPLE_TOP, M_COIN);                // at the second limit
    add_req(700, M_SHIFT | M_SECOND);
    add_req(600, M_SHIFT | M_TEST | M_SERVICE);
    add_req(900, 0);
    add_req(700, M_SHIFT | M_FIRST);            // limits now equal
    add_req(0, 0);
    add_req(200, M_SHIFT | M_SECOND);           // limits reversed
    add_req(100, 0);
    add_req(900, 0);
    add_req(450, 0);
    add_req(SAMPLE_TOP, M_SHIFT | M_FIRST | M_SECOND);
    add_req(0, M_SHIFT | M_SECOND);             // full range, mirrored
    add_req(0, 0);
    add_req(SAMPLE_TOP, 0);
    add_req(0, M_SHIFT | M_FIRST);              // both limits zero
    add_req(SAMPLE_TOP, M_SHIFT | M_SECOND);    // back to the reset limits
    add_req(1, 'h155);
    add_req(SAMPLE_TOP - 1, 'h2AA | M_COIN);
    add_req(511, M_SHIFT | (M_BUTTONS & ~(M_FIRST | M_SECOND)));

    // random: mostly plain samples, with captures mixed in
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      r    = $urandom_range(99);
      keys = $urandom_range((1 << KEY_W) - 1);
      s    = pick_sample();
      if (r < 8) begin
        add_req(s, keys | M_SHIFT | M_FIRST);
      end else if (r < 16) begin
        add_req(s, (keys | M_SHIFT | M_SECOND) & ~M_FIRST);
      end else if (r < 20) begin
        // same value into both limits
        add_req(s, keys | M_SHIFT | M_FIRST);
        add_req(s, (keys | M_SHIFT | M_SECOND) & ~M_FIRST);
      end else if (r < 26) begin
        add_req(s, keys | M_SHIFT);
      end else if (r < 32) begin
        add_req(s, keys);
      end else begin
        add_req(s, keys & ~M_SHIFT);
      end
    end

    repeat (RESET_CYC) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (accept_count < 160) @(posedge clk_i);
    send_idle_pct = 49;
    recv_idle_pct = 16;
    while (accept_count < 320) @(posedge clk_i);
    send_idle_pct = 0;
    recv_idle_pct = 0;

    while (pending_reqs.size() != 0 || s_axis_tvalid_i) @(posedge clk_i);
    while (lever_expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);

    if (mismatch_count == 0 && lever_expect_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/lcs_pkg.sv
rtl/core/lcs_ctrl.sv
rtl/core/lcs_dp.sv
rtl/core/lever_calibrate_clamp_scale_top.sv
sim/tb_lever_calibrate_clamp_scale_top.sv
